/* src/dq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the bounded double-ended queue.
// ---------------------------------------------------------------------------
package dq_pkg;

   localparam int OP_W       = 3;
   localparam int ST_W       = 2;
   localparam int WORD_W     = 32;
   localparam int POS_W      = 4;
   localparam int OCC_W      = 5;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int REQ_PAD_W  = REQ_DATA_W - WORD_W - POS_W;
   localparam int RSP_PAD_W  = RSP_DATA_W - WORD_W - OCC_W;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_LEFT  = 3'd0,
      OP_PUSH_RIGHT = 3'd1,
      OP_POP_LEFT   = 3'd2,
      OP_POP_RIGHT  = 3'd3,
      OP_REMOVE_AT  = 3'd4,
      OP_READ_AT    = 3'd5
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEL_HOLD  = 2'd0,
      SEL_LOAD  = 2'd1,
      SEL_LEFT  = 2'd2,
      SEL_RIGHT = 2'd3
   } cell_sel_type;

endpackage

/* src/dq_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dq_cell
// One storage cell of the queue chain: holds a word, loads a new one, or
// takes the word of its left or right neighbor.
// ---------------------------------------------------------------------------
module dq_cell
   import dq_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  cell_sel_type          sel,
   input  logic [DATA_WIDTH-1:0] push_word,
   input  logic [DATA_WIDTH-1:0] left_word,
   input  logic [DATA_WIDTH-1:0] right_word,
   output logic [DATA_WIDTH-1:0] word_out
);

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   always_comb begin
      unique case (sel)
         SEL_LOAD:  word_in = push_word;
         SEL_LEFT:  word_in = left_word;
         SEL_RIGHT: word_in = right_word;
         default:   word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

/* src/double_ended_queue_with_remove_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_ended_queue_with_remove_unit
// Bounded double-ended queue of signed words with push, pop, remove and read.
// ---------------------------------------------------------------------------
// Channel  Direction  tdata (low bit up)                       tuser
// req      in         push_value[31:0], position[35:32], pad   operation[2:0]
// rsp      out        data_out[31:0], occupancy[36:32], pad    status[1:0]
//
// Every request's response is registered and appears in the next cycle, so
// one request per cycle is sustained while rsp_tready is held high.
// The entries live in a chain of cells; every cell that moves does so in the same cycle.
// Reset clears the count and the response valid; cell contents need no reset.
// A request is taken while the response register is empty or being drained.
// ---------------------------------------------------------------------------
module double_ended_queue_with_remove_unit
   import dq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // push_value, position, zero pad
   input  logic [OP_W-1:0]       req_tuser,   // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // data_out, occupancy, zero pad
   output logic [ST_W-1:0]       rsp_tuser    // status
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic                  req_fire;
   op_type                op;
   logic [WORD_W-1:0]     push_value;
   logic [POS_W-1:0]      position;
   logic [DATA_WIDTH-1:0] push_word;

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            rsp_status_ff;
   status_type            rsp_status_in;
   logic [WORD_W-1:0]     rsp_data_ff;
   logic [WORD_W-1:0]     rsp_data_in;
   logic [OCC_W-1:0]      rsp_occ_ff;

   logic                  full;
   logic                  empty;
   logic                  pos_ok;
   logic                  shift_right;
   logic                  load_tail;
   logic                  shrink_en;
   logic [CMP_W-1:0]      shrink_from;
   logic                  take_word;
   logic [CMP_W-1:0]      rd_idx;
   logic [DATA_WIDTH-1:0] rd_word;

   cell_sel_type          cell_sel  [DEPTH];
   logic [DATA_WIDTH-1:0] cell_word [DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign push_value = req_tdata[WORD_W-1:0];
   assign position   = req_tdata[WORD_W+POS_W-1:WORD_W];
   assign push_word  = DATA_WIDTH'($signed(push_value));

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign pos_ok = (CMP_W'(position) < CMP_W'(count_ff));

   always_comb begin
      shift_right   = 1'b0;
      load_tail     = 1'b0;
      shrink_en     = 1'b0;
      shrink_from   = '0;
      take_word     = 1'b0;
      rd_idx        = CMP_W'(position);
      rsp_status_in = ST_OK;
      count_in      = count_ff;
      unique case (op)
         OP_PUSH_LEFT, OP_PUSH_RIGHT: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               shift_right = (op == OP_PUSH_LEFT);
               load_tail   = (op == OP_PUSH_RIGHT);
               count_in    = CNT_W'(count_ff + 1'b1);
            end
         end
         OP_POP_LEFT, OP_POP_RIGHT: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               take_word = 1'b1;
               count_in  = CNT_W'(count_ff - 1'b1);
               if (op == OP_POP_LEFT) begin
                  rd_idx    = '0;
                  shrink_en = 1'b1;
               end else begin
                  rd_idx = CMP_W'(count_ff - 1'b1);
               end
            end
         end
         OP_REMOVE_AT, OP_READ_AT: begin
            if (!pos_ok) begin
               rsp_status_in = ST_RANGE;
            end else begin
               take_word = 1'b1;
               if (op == OP_REMOVE_AT) begin
                  shrink_en   = 1'b1;
                  shrink_from = CMP_W'(position);
                  count_in    = CNT_W'(count_ff - 1'b1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CMP_W'(i) == rd_idx) begin
            rd_word = cell_word[i];
         end
      end
      rsp_data_in = take_word ? WORD_W'($signed(rd_word)) : '0;
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_sel[i] = SEL_HOLD;
         if (req_fire) begin
            priority if (shift_right) begin
               cell_sel[i] = SEL_LEFT;
            end else if (load_tail && (CMP_W'(i) == CMP_W'(count_ff))) begin
               cell_sel[i] = SEL_LOAD;
            end else if (shrink_en && (CMP_W'(i) >= shrink_from)) begin
               cell_sel[i] = SEL_RIGHT;
            end else begin
               cell_sel[i] = SEL_HOLD;
            end
         end
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_word;
      logic [DATA_WIDTH-1:0] right_word;
      if (g == 0) begin : g_first
         assign left_word = push_word;
      end else begin : g_inner_left
         assign left_word = cell_word[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_word = cell_word[g];
      end else begin : g_inner_right
         assign right_word = cell_word[g+1];
      end
      dq_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .sel       (cell_sel[g]),
         .push_word (push_word),
         .left_word (left_word),
         .right_word(right_word),
         .word_out  (cell_word[g])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_occ_ff    <= OCC_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_occ_ff, rsp_data_ff};

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Queue count exceeds its depth.");

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (count_ff == $past(count_ff))
                || (count_ff == CNT_W'($past(count_ff) + 1'b1))
                || (count_ff == CNT_W'($past(count_ff) - 1'b1)))
      else $error("Queue count moved by more than one entry.");

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff && (rsp_occ_ff == OCC_W'(count_ff)))
      else $error("Response occupancy does not match the queue count.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_data_ff == '0))
      else $error("Failed request returned nonzero data.");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (rsp_status_in == ST_FULL)) |=> (count_ff == $past(count_ff)))
      else $error("Push into a full queue changed the count.");

endmodule
